// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions that report through $error
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define FSOA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FSOA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fsoa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsoa_pkg
// types and constants shared by the fixed size object allocator
// ----------------------------------------------------------------------------
package fsoa_pkg;

    localparam int OSZ_W      = 12;     // object size register
    localparam int ADDR_W     = 16;     // byte address in the pool
    localparam int ID_W       = 14;     // slot id including the empty marker
    localparam int IDX_W      = 13;     // slot id as a table index
    localparam int CNT_W      = 14;
    localparam int SLOT_W     = 13;     // slot bytes, up to 4100
    localparam int SLAB_W     = 17;     // slab bytes, up to 65536
    localparam int PER_W      = 15;     // slots per slab
    localparam int SHAMT_W    = 5;
    localparam int ST_W       = 2;
    localparam int SLB_OUT_W  = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    localparam int SLOT_CAP   = 8192;
    localparam int ADDR_SPAN  = 65536;
    localparam int HDR_BYTES  = 4;
    localparam int ROUND_MASK = 3;
    localparam int UNIT_BYTES = 64;
    localparam int UNIT_SHIFT = 6;
    localparam int OSZ_RESET  = 16;

    localparam logic [ID_W-1:0] LIST_EMPTY = ID_W'(SLOT_CAP);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM  = 2'd1;
    localparam logic [ST_W-1:0] ST_REJ  = 2'd2;
    localparam logic [ST_W-1:0] ST_NULL = 2'd3;

    // one entry of the slot table: allocation mark and free list link
    typedef struct packed {
        logic              in_use;
        logic [ID_W-1:0]   link_id;
        logic [ADDR_W-1:0] link_addr;
    } t_link;

    typedef struct packed {
        logic            accept;
        logic            lay_slot;
        logic            lay_order;
        logic            div_lay;
        logic            lay_per;
        logic            grow_init;
        logic            grow_step;
        logic            grow_done;
        logic            rd_head;
        logic            pop_wr;
        logic            free_start;
        logic            free_id;
        logic            free_wr;
        logic            res_load;
        logic [ST_W-1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic kind_free;
        logic addr_null;
        logic head_empty;
        logic grow_ok;
        logic grow_last;
        logic free_pre_ok;
        logic div_done;
        logic free_hit;
        logic in_use;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/fixed_size_object_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_size_object_allocator_top
// one object cache over a pool of slabs, free list of equal slots
// ----------------------------------------------------------------------------
// Works one transfer at a time. After reset and after every object_size write
// the block works out the slot and slab layout (one divider pass over 17 bits)
// with s_tready low. An alloc from a non-empty free list passes through the
// decode, head read and head write states before its result; an alloc that
// first grows a slab adds a grow step for each slot of the slab, since each new
// slot is linked through the single write port of the slot table. A free waits
// on the bit-serial divider that finds the slot within its slab. The next input
// is taken while a result still waits on m_tready.
module fixed_size_object_allocator_top #(
    parameter int MIN_ORDER   = 0,
    parameter int MAX_ORDER   = 6,
    parameter int MIN_OBJ_PER = 8,
    parameter int MAX_SLABS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,   // object_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // address
    input  logic        s_tuser,       // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // granted_address, allocated_count,
                                       // free_count, slab_count, zero pad
    output logic [1:0]  m_tuser        // status
);

    fsoa_pkg::t_cmd cmd;
    fsoa_pkg::t_sts sts;

    fsoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsoa_dp #(
        .MIN_ORDER   (MIN_ORDER),
        .MAX_ORDER   (MAX_ORDER),
        .MIN_OBJ_PER (MIN_OBJ_PER),
        .MAX_SLABS   (MAX_SLABS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (s_tuser),
        .i_address   (s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/fsoa_ram.sv =====
// ----------------------------------------------------------------------------
// fsoa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fsoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fsoa_div.sv =====
// ----------------------------------------------------------------------------
// fsoa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fsoa_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  take;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign take  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], take};
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

// ===== rtl/fsoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsoa_ctrl
// sequencer for layout set-up, alloc, slab growth and free
// ----------------------------------------------------------------------------
module fsoa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  fsoa_pkg::t_sts  i_sts,
    output fsoa_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_LAY0     = 4'd0;
    localparam logic [3:0] S_LAY1     = 4'd1;
    localparam logic [3:0] S_LAY2     = 4'd2;
    localparam logic [3:0] S_LAY3     = 4'd3;
    localparam logic [3:0] S_IDLE     = 4'd4;
    localparam logic [3:0] S_DEC      = 4'd5;
    localparam logic [3:0] S_GROW_CHK = 4'd6;
    localparam logic [3:0] S_GROW     = 4'd7;
    localparam logic [3:0] S_POP_RD   = 4'd8;
    localparam logic [3:0] S_POP_WR   = 4'd9;
    localparam logic [3:0] S_FREE_CHK = 4'd10;
    localparam logic [3:0] S_FREE_DIV = 4'd11;
    localparam logic [3:0] S_FREE_RD  = 4'd12;
    localparam logic [3:0] S_FREE_WR  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [fsoa_pkg::ST_W-1:0] r_status;
    logic [fsoa_pkg::ST_W-1:0] n_status;
    logic                      ready;

    assign ready      = (r_state == S_IDLE) && !i_cfg_we;
    assign o_s_tready = ready;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            S_LAY0: begin
                o_cmd.lay_slot = 1'b1;
                n_state        = S_LAY1;
            end
            S_LAY1: begin
                o_cmd.lay_order = 1'b1;
                n_state         = S_LAY2;
            end
            S_LAY2: begin
                o_cmd.div_lay = 1'b1;
                n_state       = S_LAY3;
            end
            S_LAY3: begin
                if (i_sts.div_done) begin
                    o_cmd.lay_per = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid && ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_sts.kind_free) begin
                    n_state = i_sts.head_empty ? S_GROW_CHK : S_POP_RD;
                end else if (i_sts.addr_null) begin
                    n_status = fsoa_pkg::ST_NULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_FREE_CHK;
                end
            end
            S_GROW_CHK: begin
                if (i_sts.grow_ok) begin
                    o_cmd.grow_init = 1'b1;
                    n_state         = S_GROW;
                end else begin
                    n_status = fsoa_pkg::ST_OOM;
                    n_state  = S_DONE;
                end
            end
            S_GROW: begin
                o_cmd.grow_step = 1'b1;
                if (i_sts.grow_last) begin
                    o_cmd.grow_done = 1'b1;
                    n_state         = S_POP_RD;
                end
            end
            S_POP_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.pop_wr = 1'b1;
                n_status     = fsoa_pkg::ST_OK;
                n_state      = S_DONE;
            end
            S_FREE_CHK: begin
                if (i_sts.free_pre_ok) begin
                    o_cmd.free_start = 1'b1;
                    n_state          = S_FREE_DIV;
                end else begin
                    n_status = fsoa_pkg::ST_REJ;
                    n_state  = S_DONE;
                end
            end
            S_FREE_DIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.free_hit) begin
                        o_cmd.free_id = 1'b1;
                        n_state       = S_FREE_RD;
                    end else begin
                        n_status = fsoa_pkg::ST_REJ;
                        n_state  = S_DONE;
                    end
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                // the mark doubles as the double free check
                if (i_sts.in_use) begin
                    o_cmd.free_wr = 1'b1;
                    n_status      = fsoa_pkg::ST_OK;
                end else begin
                    n_status = fsoa_pkg::ST_REJ;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_LAY0;
            end
        endcase
        // a new object size means a new layout
        if (i_cfg_we) begin
            n_state = S_LAY0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LAY0;
            r_status <= fsoa_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

// ===== rtl/fsoa_dp.sv =====
// ----------------------------------------------------------------------------
// fsoa_dp
// layout registers, free list head, slot table, counters and result register
// ----------------------------------------------------------------------------
module fsoa_dp #(
    parameter int MIN_ORDER   = 0,
    parameter int MAX_ORDER   = 6,
    parameter int MIN_OBJ_PER = 8,
    parameter int MAX_SLABS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fsoa_pkg::OSZ_W-1:0]        i_cfg_wdata,
    input  logic                              i_kind,
    input  logic [fsoa_pkg::ADDR_W-1:0]       i_address,
    input  fsoa_pkg::t_cmd                    i_cmd,
    output fsoa_pkg::t_sts                    o_sts,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [fsoa_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic [fsoa_pkg::ST_W-1:0]         o_m_tuser
);

    localparam int ORD_W  = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int NSL_W  = $clog2(MAX_SLABS + 1);
    localparam int NEED_W = 20;
    localparam int FID_W  = NSL_W + fsoa_pkg::PER_W + 2;
    localparam int ADDR_W = fsoa_pkg::ADDR_W;
    localparam int ID_W   = fsoa_pkg::ID_W;
    localparam int IDX_W  = fsoa_pkg::IDX_W;
    localparam int CNT_W  = fsoa_pkg::CNT_W;
    localparam int SLOT_W = fsoa_pkg::SLOT_W;
    localparam int SLAB_W = fsoa_pkg::SLAB_W;
    localparam int PER_W  = fsoa_pkg::PER_W;
    localparam int PAD_W  = fsoa_pkg::OUT_DATA_W - fsoa_pkg::SLB_OUT_W - 2 * CNT_W - ADDR_W;

    // layout
    logic [fsoa_pkg::OSZ_W-1:0]   r_osz;
    logic [SLOT_W-1:0]            r_slot;
    logic [ORD_W-1:0]             r_order;
    logic [PER_W-1:0]             r_per;
    // allocator state
    logic [ID_W-1:0]              r_head_id;
    logic [ADDR_W-1:0]            r_head_addr;
    logic [CNT_W-1:0]             r_used;
    logic [CNT_W-1:0]             r_idle;
    logic [NSL_W-1:0]             r_slabs;
    logic [ID_W-1:0]              r_next_id;
    logic [SLAB_W-1:0]            r_base;
    // per item working registers
    logic [PER_W-1:0]             r_gi;
    logic [SLAB_W-1:0]            r_gaddr;
    logic                         r_kind;
    logic [ADDR_W-1:0]            r_addr;
    logic [ADDR_W-1:0]            r_grant;
    logic [NSL_W-1:0]             r_sidx;
    logic [IDX_W-1:0]             r_fid;
    // result register
    logic                         r_mvalid;
    logic [fsoa_pkg::ST_W-1:0]    r_mstatus;
    logic [ADDR_W-1:0]            r_mgrant;
    logic [CNT_W-1:0]             r_mused;
    logic [CNT_W-1:0]             r_midle;
    logic [fsoa_pkg::SLB_OUT_W-1:0] r_mslabs;

    logic [SLOT_W-1:0]            slot_calc;
    logic [NEED_W-1:0]            need;
    logic [ORD_W-1:0]             ord_sel;
    logic [fsoa_pkg::SHAMT_W-1:0] shamt;
    logic [SLAB_W-1:0]            slab;
    logic [ADDR_W-1:0]            h;
    logic [ADDR_W-1:0]            s_full;
    logic [SLAB_W-1:0]            off;
    logic [PER_W-1:0]             gid_sum;
    logic [FID_W-1:0]             fid_full;
    logic                         div_start;
    logic [SLAB_W-1:0]            div_dividend;
    logic [SLAB_W-1:0]            div_quo;
    logic [SLOT_W-1:0]            div_rem;
    logic                         div_done;
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [IDX_W-1:0]             ram_raddr;
    fsoa_pkg::t_link              ram_wdata;
    fsoa_pkg::t_link              ram_rdata;

    // slot is header plus size rounded up to a word
    assign slot_calc = SLOT_W'(fsoa_pkg::HDR_BYTES)
                     + ((SLOT_W'(r_osz) + SLOT_W'(fsoa_pkg::ROUND_MASK))
                        & ~SLOT_W'(fsoa_pkg::ROUND_MASK));
    assign need = NEED_W'(MIN_OBJ_PER) * NEED_W'(r_slot);

    // smallest order whose slab holds enough slots, else the largest
    always_comb begin
        ord_sel = ORD_W'(MAX_ORDER);
        for (int o = MAX_ORDER; o >= MIN_ORDER; o--) begin
            if ((NEED_W'(fsoa_pkg::UNIT_BYTES) << o) >= need) begin
                ord_sel = ORD_W'(o);
            end
        end
    end

    assign shamt = fsoa_pkg::SHAMT_W'(r_order) + fsoa_pkg::SHAMT_W'(fsoa_pkg::UNIT_SHIFT);
    assign slab  = SLAB_W'(1) << shamt;

    // free address split: slab index by shift, offset by mask
    assign h      = r_addr - ADDR_W'(fsoa_pkg::HDR_BYTES);
    assign s_full = h >> shamt;
    assign off    = {1'b0, h} & (slab - SLAB_W'(1));

    assign gid_sum  = PER_W'(r_next_id) + r_gi;
    assign fid_full = FID_W'(r_sidx) * FID_W'(r_per) + FID_W'(div_quo);

    assign div_start    = i_cmd.div_lay | i_cmd.free_start;
    assign div_dividend = i_cmd.div_lay ? slab : off;

    fsoa_div #(
        .DIVIDEND_W (SLAB_W),
        .DIVISOR_W  (SLOT_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_slot),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    // slot table write and read selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fid;
        ram_wdata = '{in_use: 1'b0, link_id: r_head_id, link_addr: r_head_addr};
        if (i_cmd.grow_step) begin
            ram_we    = 1'b1;
            ram_waddr = gid_sum[IDX_W-1:0];
        end else if (i_cmd.pop_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_head_id[IDX_W-1:0];
            ram_wdata = '{in_use: 1'b1, link_id: ram_rdata.link_id,
                          link_addr: ram_rdata.link_addr};
        end else if (i_cmd.free_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_fid;
        end
    end

    assign ram_raddr = i_cmd.rd_head ? r_head_id[IDX_W-1:0] : r_fid;

    fsoa_ram #(
        .WIDTH ($bits(fsoa_pkg::t_link)),
        .DEPTH (fsoa_pkg::SLOT_CAP)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // status towards the sequencer
    always_comb begin
        o_sts.kind_free   = (r_kind == fsoa_pkg::KIND_FREE);
        o_sts.addr_null   = (r_addr == '0);
        o_sts.head_empty  = (r_head_id == fsoa_pkg::LIST_EMPTY);
        o_sts.grow_ok     = (r_slabs < NSL_W'(MAX_SLABS)) && (r_per != '0)
                          && ((17'(r_next_id) + 17'(r_per)) <= 17'(fsoa_pkg::SLOT_CAP))
                          && ((18'(r_base) + 18'(slab)) <= 18'(fsoa_pkg::ADDR_SPAN));
        o_sts.grow_last   = (r_gi == (r_per - PER_W'(1)));
        o_sts.free_pre_ok = (r_addr >= ADDR_W'(fsoa_pkg::HDR_BYTES)) && (r_per != '0)
                          && (s_full < ADDR_W'(r_slabs));
        o_sts.div_done    = div_done;
        o_sts.free_hit    = (div_rem == '0) && (div_quo < SLAB_W'(r_per))
                          && (fid_full < FID_W'(fsoa_pkg::SLOT_CAP));
        o_sts.in_use      = ram_rdata.in_use;
        o_sts.out_busy    = r_mvalid && !i_m_tready;
    end

    // control state: config register, list head, counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osz     <= fsoa_pkg::OSZ_W'(fsoa_pkg::OSZ_RESET);
            r_head_id <= fsoa_pkg::LIST_EMPTY;
            r_used    <= '0;
            r_idle    <= '0;
            r_slabs   <= '0;
            r_next_id <= '0;
            r_base    <= '0;
            r_mvalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_osz     <= i_cfg_wdata;
                r_head_id <= fsoa_pkg::LIST_EMPTY;
                r_used    <= '0;
                r_idle    <= '0;
                r_slabs   <= '0;
                r_next_id <= '0;
                r_base    <= '0;
            end else begin
                if (i_cmd.grow_step) begin
                    r_head_id   <= ID_W'(gid_sum);
                    r_head_addr <= r_gaddr[ADDR_W-1:0];
                end
                if (i_cmd.grow_done) begin
                    r_idle    <= r_idle + CNT_W'(r_per);
                    r_slabs   <= r_slabs + NSL_W'(1);
                    r_next_id <= r_next_id + ID_W'(r_per);
                    r_base    <= r_base + slab;
                end
                if (i_cmd.pop_wr) begin
                    r_head_id   <= ram_rdata.link_id;
                    r_head_addr <= ram_rdata.link_addr;
                    r_used      <= r_used + CNT_W'(1);
                    r_idle      <= r_idle - CNT_W'(1);
                end
                if (i_cmd.free_wr) begin
                    r_head_id   <= ID_W'(r_fid);
                    r_head_addr <= r_addr;
                    r_used      <= r_used - CNT_W'(1);
                    r_idle      <= r_idle + CNT_W'(1);
                end
            end
            if (i_cmd.res_load) begin
                r_mvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.lay_slot) begin
            r_slot <= slot_calc;
        end
        if (i_cmd.lay_order) begin
            r_order <= ord_sel;
        end
        if (i_cmd.lay_per) begin
            r_per <= PER_W'(div_quo);
        end
        if (i_cmd.grow_init) begin
            r_gi    <= '0;
            r_gaddr <= r_base + SLAB_W'(fsoa_pkg::HDR_BYTES);
        end else if (i_cmd.grow_step) begin
            r_gi    <= r_gi + PER_W'(1);
            r_gaddr <= r_gaddr + SLAB_W'(r_slot);
        end
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_addr  <= i_address;
            r_grant <= '0;
        end else if (i_cmd.pop_wr) begin
            r_grant <= r_head_addr;
        end
        if (i_cmd.free_start) begin
            r_sidx <= NSL_W'(s_full);
        end
        if (i_cmd.free_id) begin
            r_fid <= fid_full[IDX_W-1:0];
        end
        if (i_cmd.res_load) begin
            r_mstatus <= i_cmd.res_status;
            r_mgrant  <= r_grant;
            r_mused   <= r_used;
            r_midle   <= r_idle;
            r_mslabs  <= fsoa_pkg::SLB_OUT_W'(r_slabs);
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_mslabs, r_midle, r_mused, r_mgrant};
    assign o_m_tuser  = r_mstatus;

endmodule

// ===== rtl/fsoa_check.sv =====
// ----------------------------------------------------------------------------
// fsoa_check
// port level checks on the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsoa_check #(
    parameter int MAX_SLABS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [11:0] i_cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result keeps its contents
    `FSOA_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // only a successful transfer may carry an address
    `FSOA_ASSERT(a_grant_ok, i_clk, i_rst_n, m_tvalid && (m_tuser != fsoa_pkg::ST_OK) |-> (m_tdata[15:0] == 16'd0), "address on a failed result")

    `FSOA_ASSERT(a_slab_cap, i_clk, i_rst_n, m_tvalid |-> (32'(m_tdata[48:44]) <= MAX_SLABS), "slab count beyond budget")

    // layout is rebuilt before any new input
    `FSOA_ASSERT(a_cfg_stall, i_clk, i_rst_n, i_cfg_we |=> !s_tready, "input taken during layout set-up")

    `FSOA_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !m_tvalid && !s_tready, "handshake active after reset")

endmodule

bind fixed_size_object_allocator_top fsoa_check #(.MAX_SLABS(MAX_SLABS)) u_check (.*);
